/* rtl/pan_tilt_angle_stepper_top_defines.svh */
// Assertion macros for the pan/tilt angle stepper.
// Used by pan_tilt_angle_stepper_top; no other dependencies.
// Macros compile to nothing when SYNTHESIS is defined.
`ifndef PAN_TILT_ANGLE_STEPPER_TOP_DEFINES_SVH
`define PAN_TILT_ANGLE_STEPPER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PTAS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ptas assertion failed");
`define PTAS_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("ptas assertion failed");
`else
`define PTAS_ASSERT(name, clk, rst, prop)
`define PTAS_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

/* rtl/ptas_pkg.sv */
// Shared types, constants and angle helpers for the pan/tilt angle stepper.
// No dependencies; imported by every module of the block.
package ptas_pkg;

   localparam logic [7:0] MAX_ANGLE = 8'd180;
   localparam logic [7:0] HOME_DEFAULT = 8'd90;
   localparam logic [7:0] RESET_ANGLE = (HOME_DEFAULT > MAX_ANGLE) ? MAX_ANGLE : HOME_DEFAULT;

   // command codes
   localparam logic [2:0] MODE_TICK       = 3'd0;
   localparam logic [2:0] MODE_STEP       = 3'd1;
   localparam logic [2:0] MODE_HOLD_START = 3'd2;
   localparam logic [2:0] MODE_HOLD_STOP  = 3'd3;
   localparam logic [2:0] MODE_HOME       = 3'd4;

   // step directions
   localparam logic [1:0] DIR_PAN_MINUS  = 2'd0;
   localparam logic [1:0] DIR_PAN_PLUS   = 2'd1;
   localparam logic [1:0] DIR_TILT_MINUS = 2'd2;
   localparam logic [1:0] DIR_TILT_PLUS  = 2'd3;

   // csr indexes
   localparam logic [1:0] CSR_STEP_SIZE       = 2'd0;
   localparam logic [1:0] CSR_REPEAT_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_HOME_PAN        = 2'd2;
   localparam logic [1:0] CSR_HOME_TILT       = 2'd3;

   localparam logic [7:0]  STEP_SIZE_RESET = 8'd2;
   localparam logic [15:0] INTERVAL_RESET  = 16'd100;

   typedef struct packed {
      logic [2:0] mode;
      logic [1:0] direction;
   } req_type;

   typedef struct packed {
      logic [7:0] pan_out;
      logic [7:0] tilt_out;
      logic       moved;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  step_size;
      logic [15:0] repeat_interval;
      logic [7:0]  home_pan;
      logic [7:0]  home_tilt;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  pan_angle;
      logic [7:0]  tilt_angle;
      logic        hold_active;
      logic [1:0]  hold_direction;
      logic [15:0] repeat_countdown;
   } state_type;

   function automatic logic [7:0] clamp_angle(input logic [8:0] value);
      logic [7:0] res;
      if (value > {1'b0, MAX_ANGLE}) begin
         res = MAX_ANGLE;
      end else begin
         res = value[7:0];
      end
      return res;
   endfunction

   // saturating step of one axis
   function automatic logic [7:0] step_angle(input logic [7:0] angle,
                                             input logic [7:0] step,
                                             input logic       plus);
      logic [8:0] sum;
      logic [7:0] res;
      sum = {1'b0, angle} + {1'b0, step};
      if (plus) begin
         res = clamp_angle(sum);
      end else if (step >= angle) begin
         res = 8'd0;
      end else begin
         res = clamp_angle({1'b0, angle - step});
      end
      return res;
   endfunction

endpackage

/* rtl/ptas_cfg_regs.sv */
// Configuration register file of the pan/tilt angle stepper.
// Depends on ptas_pkg for the csr indexes, reset values and cfg_type.
module ptas_cfg_regs (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   output ptas_pkg::cfg_type cfg
);
   import ptas_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_STEP_SIZE:       cfg_in.step_size = csr_wdata[7:0];
            CSR_REPEAT_INTERVAL: cfg_in.repeat_interval = csr_wdata;
            CSR_HOME_PAN:        cfg_in.home_pan = csr_wdata[7:0];
            CSR_HOME_TILT:       cfg_in.home_tilt = csr_wdata[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_size       <= STEP_SIZE_RESET;
         cfg_ff.repeat_interval <= INTERVAL_RESET;
         cfg_ff.home_pan        <= HOME_DEFAULT;
         cfg_ff.home_tilt       <= HOME_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/ptas_next_state.sv */
// Combinational command decode and angle update of the pan/tilt stepper.
// Depends on ptas_pkg for codes, types and the saturating step helpers.
module ptas_next_state (
   input  ptas_pkg::req_type   item,
   input  ptas_pkg::cfg_type   cfg,
   input  ptas_pkg::state_type cur,
   output ptas_pkg::state_type nxt,
   output ptas_pkg::rsp_type   rsp
);
   import ptas_pkg::*;

   logic       do_step;
   logic [1:0] step_dir;
   logic       moved;

   always_comb begin
      nxt      = cur;
      do_step  = 1'b0;
      step_dir = item.direction;
      moved    = 1'b0;

      case (item.mode)
         MODE_TICK: begin
            if (cur.hold_active) begin
               if (cur.repeat_countdown <= 16'd1) begin
                  do_step              = 1'b1;
                  step_dir             = cur.hold_direction;
                  nxt.repeat_countdown = cfg.repeat_interval;
               end else begin
                  nxt.repeat_countdown = cur.repeat_countdown - 16'd1;
               end
            end
         end
         MODE_STEP: begin
            do_step = 1'b1;
         end
         MODE_HOLD_START: begin
            nxt.hold_active      = 1'b1;
            nxt.hold_direction   = item.direction;
            nxt.repeat_countdown = 16'd0;
         end
         MODE_HOLD_STOP: begin
            nxt.hold_active = 1'b0;
         end
         MODE_HOME: begin
            nxt.hold_active = 1'b0;
            nxt.pan_angle   = clamp_angle({1'b0, cfg.home_pan});
            nxt.tilt_angle  = clamp_angle({1'b0, cfg.home_tilt});
            moved           = 1'b1;
         end
         default: begin
            nxt = cur;
         end
      endcase

      if (do_step) begin
         moved = 1'b1;
         case (step_dir)
            DIR_PAN_MINUS:  nxt.pan_angle  = step_angle(cur.pan_angle, cfg.step_size, 1'b0);
            DIR_PAN_PLUS:   nxt.pan_angle  = step_angle(cur.pan_angle, cfg.step_size, 1'b1);
            DIR_TILT_MINUS: nxt.tilt_angle = step_angle(cur.tilt_angle, cfg.step_size, 1'b0);
            DIR_TILT_PLUS:  nxt.tilt_angle = step_angle(cur.tilt_angle, cfg.step_size, 1'b1);
            default:        nxt.tilt_angle = cur.tilt_angle;
         endcase
      end
   end

   assign rsp.pan_out  = nxt.pan_angle;
   assign rsp.tilt_out = nxt.tilt_angle;
   assign rsp.moved    = moved;

endmodule

/* rtl/pan_tilt_angle_stepper_top.sv */
// Pan/tilt angle stepper, top level.
// A request passes through the input register, then the result register, before rsp_valid.
// Throughput: one transaction per cycle when not stalled; one saturating add and countdown step.
// Reset (synchronous, active high): angles 90, hold off, countdown 0, csrs to defaults.
// Depends on ptas_pkg, ptas_cfg_regs, ptas_next_state and the assertion macro header.
`include "pan_tilt_angle_stepper_top_defines.svh"

module pan_tilt_angle_stepper_top (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  ptas_pkg::req_type req_data,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ptas_pkg::rsp_type rsp_data,
   // csr write port
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import ptas_pkg::*;

   cfg_type   cfg;

   // input register stage
   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_item_ff;

   // architectural state and its next value
   state_type state_ff;
   state_type state_nxt;

   // result register stage
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_nxt;

   logic      out_blocked;
   logic      advance;
   logic      accept;

   // assertion terms
   logic      angles_ok;
   logic      idle_tick;

   ptas_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ptas_next_state u_next (
      .item (in_item_ff),
      .cfg  (cfg),
      .cur  (state_ff),
      .nxt  (state_nxt),
      .rsp  (rsp_nxt)
   );

   // A result held by a stalled consumer blocks only the compute stage;
   // the input register still takes a transaction while it is empty.
   assign out_blocked = rsp_valid_ff & rsp_stall;
   assign advance     = in_valid_ff & ~out_blocked;
   assign req_stall   = in_valid_ff & out_blocked;
   assign accept      = req_valid & ~req_stall;

   assign in_valid_in  = accept | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance | out_blocked;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // state commits only when the transaction moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.pan_angle        <= RESET_ANGLE;
         state_ff.tilt_angle       <= RESET_ANGLE;
         state_ff.hold_active      <= 1'b0;
         state_ff.hold_direction   <= DIR_PAN_MINUS;
         state_ff.repeat_countdown <= 16'd0;
      end else if (advance) begin
         state_ff <= state_nxt;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_nxt;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign angles_ok = (state_ff.pan_angle <= MAX_ANGLE) && (state_ff.tilt_angle <= MAX_ANGLE);
   assign idle_tick = advance && (in_item_ff.mode == MODE_TICK) && !state_ff.hold_active;

   // angles stay within range
   `PTAS_ASSERT(a_angle_range, clock, reset, angles_ok)
   // a parked input transaction is held while the result register is blocked
   `PTAS_ASSERT(a_in_hold, clock, reset, req_stall |=> (in_valid_ff && $stable(in_item_ff)))
   // a tick with no hold active never reports a move
   `PTAS_ASSERT(a_idle_tick, clock, reset, idle_tick |=> !rsp_data_ff.moved)
   // out of reset both stages are empty
   `PTAS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!in_valid_ff && !rsp_valid_ff))

endmodule
